FILE: src/ipv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv_pkg: shared types and constants of the IP address text validator
// Character codes, family and status codes, and the classified character
// beat that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ipv_pkg;

   localparam int CHAR_W   = 8;
   localparam int FAM_W    = 2;
   localparam int STATUS_W = 2;

   // default depth of the queue between front and back end (power of two)
   localparam int QUEUE_DEPTH_DEF = 2;

   // address family register codes
   localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
   localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_INVALID     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_VALID       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd2;

   // ASCII codes the classifier looks for
   localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;

   // field limits
   localparam logic [8:0] OCTET_MAX     = 9'd255;
   localparam logic [8:0] OCTET_SAT     = 9'd256;
   localparam logic [2:0] DOTS_V4       = 3'd3;
   localparam logic [2:0] DOT_SAT       = 3'd7;
   localparam logic [2:0] GROUP_MAX     = 3'd4;
   localparam logic [2:0] GROUP_SAT     = 3'd5;
   localparam logic [3:0] COLONS_FULL   = 4'd7;
   localparam logic [3:0] COLONS_TAIL   = 4'd6;
   localparam logic [3:0] COLON_SAT     = 4'd15;
   localparam logic [1:0] DCOLON_SAT    = 2'd3;
   localparam logic [1:0] CHARS_SAT     = 2'd2;

   // one classified character
   typedef struct packed {
      logic [FAM_W-1:0] fam;
      logic             is_digit;
      logic [3:0]       digit;
      logic             is_hex;
      logic             is_dot;
      logic             is_colon;
      logic             last;
   } ipv_beat_type;

endpackage
`default_nettype wire

FILE: src/ipv_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv_if: valid/ready channels of the IP address text validator
// Character channel into the block and status channel out of it.
// ----------------------------------------------------------------------------

// character channel: one address character per beat
interface ipv_req_if import ipv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// status channel: one status per string
interface ipv_rsp_if import ipv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface
`default_nettype wire

FILE: src/ipv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv_front: character front end
// Holds the address family register, accepts character beats while the
// queue has room and tags each with its class and the family in force.
// ----------------------------------------------------------------------------
module ipv_front import ipv_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [FAM_W-1:0] csr_wr_data,
   ipv_req_if.sink               req_chan,
   input  wire logic             queue_full,
   output      logic             push_valid,
   output      ipv_beat_type     push_beat
);

   logic [FAM_W-1:0] fam_ff;
   logic [FAM_W-1:0] fam_in;
   logic             is_digit;
   logic             is_lower_hex;
   logic             is_upper_hex;

   // family register
   assign fam_in = csr_wr_en ? csr_wr_data : fam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fam_ff <= FAM_V4;
      end else begin
         fam_ff <= fam_in;
      end
   end

   // character classes
   assign is_digit     = (req_chan.char_code >= CHAR_ZERO) &&
                         (req_chan.char_code <= CHAR_NINE);
   assign is_lower_hex = (req_chan.char_code >= CHAR_LOWER_A) &&
                         (req_chan.char_code <= CHAR_LOWER_F);
   assign is_upper_hex = (req_chan.char_code >= CHAR_UPPER_A) &&
                         (req_chan.char_code <= CHAR_UPPER_F);

   // handshake: take a beat whenever the queue has room
   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;

   always_comb begin
      push_beat.fam      = fam_ff;
      push_beat.is_digit = is_digit;
      push_beat.digit    = req_chan.char_code[3:0];
      push_beat.is_hex   = is_digit || is_lower_hex || is_upper_hex;
      push_beat.is_dot   = (req_chan.char_code == CHAR_DOT);
      push_beat.is_colon = (req_chan.char_code == CHAR_COLON);
      push_beat.last     = req_chan.last;
   end

endmodule
`default_nettype wire

FILE: src/ipv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv_queue: classified beat queue
// Small FIFO between front and back end. Full depends on the count only,
// so the front end never waits on the back end combinationally.
// ----------------------------------------------------------------------------
module ipv_queue import ipv_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   input  ipv_beat_type      push_beat,
   output      logic         full,
   output      logic         pop_valid,
   output      ipv_beat_type pop_beat,
   input  wire logic         pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   ipv_beat_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_beat  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule
`default_nettype wire

FILE: src/ipv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv_back: rule checker back end
// Consumes one classified beat per cycle, a last beat only once the
// previous status is taken; updates the IPv4 and IPv6 rule state and
// registers the status on the last character of a string.
module ipv_back import ipv_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         pop_valid,
   input  ipv_beat_type      pop_beat,
   output      logic         pop_ready,
   ipv_rsp_if.source         rsp_chan
);

   // rule state
   logic [8:0] oct_ff,   oct_in;
   logic [2:0] dot_ff,   dot_in;
   logic       afs_ff,   afs_in;
   logic       v4rej_ff, v4rej_in;
   logic [2:0] gl_ff,    gl_in;
   logic [3:0] ct_ff,    ct_in;
   logic [1:0] dcc_ff,   dcc_in;
   logic       prev_ff,  prev_in;
   logic       first_ff, first_in;
   logic [1:0] cs_ff,    cs_in;
   logic       tail_ff,  tail_in;
   logic       v6rej_ff, v6rej_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff,    status_in;

   // updated values before the end-of-string clear
   logic [8:0]  u_oct;
   logic [2:0]  u_dot;
   logic        u_afs;
   logic        u_v4rej;
   logic [2:0]  u_gl;
   logic [3:0]  u_ct;
   logic [1:0]  u_dcc;
   logic        u_first;
   logic [1:0]  u_cs;
   logic        u_tail;
   logic        u_v6rej;

   // decimal field step
   logic [8:0]  f_oct;
   logic [2:0]  f_dot;
   logic        f_afs;
   logic        f_v4rej;
   logic [11:0] dec_sum;

   logic        take;
   logic        v4_ok;
   logic        v6_ok;
   logic [STATUS_W-1:0] status_calc;

   // a non-last beat never needs the output register
   assign pop_ready = !pop_beat.last || !rsp_valid_ff || rsp_chan.ready;
   assign take      = pop_valid && pop_ready;

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;

   // octet value times ten plus the digit
   assign dec_sum = {oct_ff, 3'b000} + {2'b00, oct_ff, 1'b0} + {8'd0, pop_beat.digit};

   // decimal field step on the current character
   always_comb begin
      f_oct   = oct_ff;
      f_dot   = dot_ff;
      f_afs   = afs_ff;
      f_v4rej = v4rej_ff;
      if (pop_beat.is_digit) begin
         if (dec_sum > {3'b000, OCTET_MAX}) begin
            f_v4rej = 1'b1;
            f_oct   = OCTET_SAT;
         end else begin
            f_oct   = dec_sum[8:0];
         end
         f_afs = 1'b0;
      end else if (pop_beat.is_dot) begin
         if (afs_ff) begin
            f_v4rej = 1'b1;
         end
         if (dot_ff < DOT_SAT) begin
            f_dot = dot_ff + 1'b1;
         end
         f_oct = '0;
         f_afs = 1'b1;
      end else begin
         f_v4rej = 1'b1;
      end
   end

   // per-character rule update
   always_comb begin
      u_oct   = oct_ff;
      u_dot   = dot_ff;
      u_afs   = afs_ff;
      u_v4rej = v4rej_ff;
      u_gl    = gl_ff;
      u_ct    = ct_ff;
      u_dcc   = dcc_ff;
      u_first = first_ff;
      u_cs    = cs_ff;
      u_tail  = tail_ff;
      u_v6rej = v6rej_ff;

      // a leading colon must be followed by a second colon
      if (cs_ff == 2'd0) begin
         u_first = pop_beat.is_colon;
         if (pop_beat.is_colon && pop_beat.last) begin
            u_v6rej = 1'b1;
         end
      end else if (cs_ff == 2'd1 && first_ff && !pop_beat.is_colon) begin
         u_v6rej = 1'b1;
      end
      if (cs_ff < CHARS_SAT) begin
         u_cs = cs_ff + 1'b1;
      end

      if (pop_beat.is_colon) begin
         if (ct_ff < COLON_SAT) begin
            u_ct = ct_ff + 1'b1;
         end
         if (u_ct > COLONS_FULL) begin
            u_v6rej = 1'b1;
         end
         if (prev_ff) begin
            if (dcc_ff < DCOLON_SAT) begin
               u_dcc = dcc_ff + 1'b1;
            end
            if (u_dcc > 2'd1) begin
               u_v6rej = 1'b1;
            end
         end
         // trailing colon only after a double colon
         if (pop_beat.last && u_dcc == 2'd0) begin
            u_v6rej = 1'b1;
         end
         if (pop_beat.fam == FAM_V6 && !tail_ff) begin
            u_gl    = '0;
            u_oct   = '0;
            u_dot   = '0;
            u_afs   = 1'b1;
            u_v4rej = 1'b0;
         end else begin
            u_oct   = f_oct;
            u_dot   = f_dot;
            u_afs   = f_afs;
            u_v4rej = f_v4rej;
         end
      end else begin
         u_oct   = f_oct;
         u_dot   = f_dot;
         u_afs   = f_afs;
         u_v4rej = f_v4rej;
         if (!tail_ff) begin
            if (pop_beat.is_hex) begin
               if (gl_ff < GROUP_SAT) begin
                  u_gl = gl_ff + 1'b1;
               end
               if (u_gl > GROUP_MAX) begin
                  u_v6rej = 1'b1;
               end
            end else if (pop_beat.is_dot) begin
               // dotted tail: enough colons before it, but not too many
               if (ct_ff > COLONS_TAIL) begin
                  u_v6rej = 1'b1;
               end
               if (dcc_ff == 2'd0 && ct_ff < COLONS_TAIL) begin
                  u_v6rej = 1'b1;
               end
               u_tail = 1'b1;
            end else begin
               u_v6rej = 1'b1;
            end
         end
      end
   end

   // end-of-string verdict
   always_comb begin
      v4_ok = !u_v4rej && (u_dot == DOTS_V4) && !u_afs;
      v6_ok = !u_v6rej;
      if (u_tail) begin
         v6_ok = v6_ok && v4_ok;
      end else if (u_dcc == 2'd0 && u_ct != COLONS_FULL) begin
         v6_ok = 1'b0;
      end
      if (pop_beat.fam == FAM_V4) begin
         status_calc = v4_ok ? STATUS_VALID : STATUS_INVALID;
      end else if (pop_beat.fam == FAM_V6) begin
         status_calc = v6_ok ? STATUS_VALID : STATUS_INVALID;
      end else begin
         status_calc = STATUS_UNSUPPORTED;
      end
   end

   // next state: updated values, or a clean slate after the last beat
   always_comb begin
      oct_in   = oct_ff;
      dot_in   = dot_ff;
      afs_in   = afs_ff;
      v4rej_in = v4rej_ff;
      gl_in    = gl_ff;
      ct_in    = ct_ff;
      dcc_in   = dcc_ff;
      prev_in  = prev_ff;
      first_in = first_ff;
      cs_in    = cs_ff;
      tail_in  = tail_ff;
      v6rej_in = v6rej_ff;
      if (take) begin
         if (pop_beat.last) begin
            oct_in   = '0;
            dot_in   = '0;
            afs_in   = 1'b1;
            v4rej_in = 1'b0;
            gl_in    = '0;
            ct_in    = '0;
            dcc_in   = '0;
            prev_in  = 1'b0;
            first_in = 1'b0;
            cs_in    = '0;
            tail_in  = 1'b0;
            v6rej_in = 1'b0;
         end else begin
            oct_in   = u_oct;
            dot_in   = u_dot;
            afs_in   = u_afs;
            v4rej_in = u_v4rej;
            gl_in    = u_gl;
            ct_in    = u_ct;
            dcc_in   = u_dcc;
            prev_in  = pop_beat.is_colon;
            first_in = u_first;
            cs_in    = u_cs;
            tail_in  = u_tail;
            v6rej_in = u_v6rej;
         end
      end
   end

   // output register: load on a last beat, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && pop_beat.last) begin
         rsp_valid_in = 1'b1;
         status_in    = status_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff       <= '0;
         dot_ff       <= '0;
         afs_ff       <= 1'b1;
         v4rej_ff     <= 1'b0;
         gl_ff        <= '0;
         ct_ff        <= '0;
         dcc_ff       <= '0;
         prev_ff      <= 1'b0;
         first_ff     <= 1'b0;
         cs_ff        <= '0;
         tail_ff      <= 1'b0;
         v6rej_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oct_ff       <= oct_in;
         dot_ff       <= dot_in;
         afs_ff       <= afs_in;
         v4rej_ff     <= v4rej_in;
         gl_ff        <= gl_in;
         ct_ff        <= ct_in;
         dcc_ff       <= dcc_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         cs_ff        <= cs_in;
         tail_ff      <= tail_in;
         v6rej_ff     <= v6rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

FILE: src/ip_address_text_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// The status of a string is registered by the rule checker once its last
// beat has been stored in the queue and then taken from it; a last beat
// waits in the queue while an earlier status has not been taken.
// Throughput: one character per cycle except while a last beat waits.
// Reset (synchronous, active high) sets the family to IPv4, clears the
// rule state, empties the queue and drops any pending status.
// ----------------------------------------------------------------------------
// ip_address_text_validator: IPv4/IPv6 address text checker
// Front end classifies characters, a small queue decouples it from the
// back end, which applies the address rules and returns one status per
// string.
// ----------------------------------------------------------------------------
module ip_address_text_validator import ipv_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [FAM_W-1:0] csr_wr_data,
   ipv_req_if.sink               req_chan,
   ipv_rsp_if.source             rsp_chan
);

   logic         push_valid;
   ipv_beat_type push_beat;
   logic         queue_full;
   logic         pop_valid;
   ipv_beat_type pop_beat;
   logic         pop_ready;

   // character classification and family register
   ipv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_beat   (push_beat)
   );

   // beat queue
   ipv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_beat   (pop_beat),
      .pop_ready  (pop_ready)
   );

   // rule checking and status register
   ipv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_beat  (pop_beat),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
